FILE: hdl/sssf_pkg.sv
// Shared types, constants and the BCD-to-segment decoder for the
// seven-segment scan and flash block. No dependencies.
package sssf_pkg;

  // Default and upper bound of the number of digit slots.
  localparam int unsigned MAX_DIGITS_DEFAULT = 8;
  // Digit count after reset.
  localparam int unsigned DIGIT_COUNT_RESET  = 8;

  // Segment masks, a is bit 0 through g is bit 6.
  localparam logic [6:0] SEG_A = 7'h01;
  localparam logic [6:0] SEG_B = 7'h02;
  localparam logic [6:0] SEG_C = 7'h04;
  localparam logic [6:0] SEG_D = 7'h08;
  localparam logic [6:0] SEG_E = 7'h10;
  localparam logic [6:0] SEG_F = 7'h20;
  localparam logic [6:0] SEG_G = 7'h40;
  localparam logic [6:0] SEGMENTS_BLANK = 7'h00;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    CFG_DIGIT_COUNT  = 4'd0,
    CFG_FLASH_FIRST  = 4'd1,
    CFG_FLASH_LAST   = 4'd2,
    CFG_FLASH_PERIOD = 4'd3
  } cfg_reg_e;

  // Register contents as the scanner sees them; eff_count is already limited.
  typedef struct packed {
    logic [3:0]  eff_count;
    logic [2:0]  flash_first;
    logic [2:0]  flash_last;
    logic [15:0] flash_period;
  } cfg_t;

  // One-cycle events that follow a register write.
  typedef struct packed {
    logic restart;
    logic flash_clr;
  } cfg_evt_t;

  // A digit write as handed to the store.
  typedef struct packed {
    logic       en;
    logic       clear;
    logic [2:0] position;
    logic [3:0] bcd;
  } store_wr_t;

  function automatic logic [6:0] bcd_to_seg(input logic [3:0] bcd);
    logic [6:0] seg;
    case (bcd)
      4'd0: seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
      4'd1: seg = SEG_B | SEG_C;
      4'd2: seg = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
      4'd3: seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
      4'd4: seg = SEG_B | SEG_C | SEG_F | SEG_G;
      4'd5: seg = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
      4'd6: seg = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
      4'd7: seg = SEG_A | SEG_B | SEG_C;
      4'd8: seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F
                  | SEG_G;
      // The nine is drawn without the bottom segment.
      4'd9: seg = SEG_A | SEG_B | SEG_C | SEG_F | SEG_G;
      default: seg = SEGMENTS_BLANK;
    endcase
    return seg;
  endfunction

endpackage

FILE: hdl/sssf_cfg.sv
// Configuration registers of the scan and flash block.
// Depends on sssf_pkg for cfg_t, cfg_evt_t and the register indexes.
module sssf_cfg import sssf_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output cfg_t        cfg_o,
  output cfg_evt_t    evt_o
);

  logic [3:0]  count_q;
  logic [2:0]  first_q;
  logic [2:0]  last_q;
  logic [15:0] period_q;
  cfg_evt_t    evt_q;
  cfg_evt_t    evt_d;
  logic        wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  always_comb begin
    evt_d = '0;
    if (wr_en) begin
      case (cfg_index_i)
        CFG_DIGIT_COUNT:  evt_d.restart   = 1'b1;
        CFG_FLASH_FIRST:  evt_d.flash_clr = 1'b1;
        CFG_FLASH_LAST:   evt_d.flash_clr = 1'b1;
        CFG_FLASH_PERIOD: evt_d.flash_clr = 1'b1;
        default:          evt_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 4'(DIGIT_COUNT_RESET);
      first_q  <= '0;
      last_q   <= '0;
      period_q <= '0;
      evt_q    <= '0;
    end else begin
      evt_q <= evt_d;
      if (wr_en) begin
        case (cfg_index_i)
          CFG_DIGIT_COUNT:  count_q  <= cfg_data_i[3:0];
          CFG_FLASH_FIRST:  first_q  <= cfg_data_i[2:0];
          CFG_FLASH_LAST:   last_q   <= cfg_data_i[2:0];
          CFG_FLASH_PERIOD: period_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // A count of zero scans one digit; the count never exceeds the slot count.
  always_comb begin
    if (count_q == 4'd0) begin
      cfg_o.eff_count = 4'd1;
    end else if ({1'b0, count_q} > 5'(MAX_DIGITS)) begin
      cfg_o.eff_count = 4'(MAX_DIGITS);
    end else begin
      cfg_o.eff_count = count_q;
    end
    cfg_o.flash_first  = first_q;
    cfg_o.flash_last   = last_q;
    cfg_o.flash_period = period_q;
  end

  assign evt_o = evt_q;

endmodule

FILE: hdl/sssf_store.sv
// Digit store: one segment image per digit slot, with a whole-store clear.
// Depends on sssf_pkg for store_wr_t and the BCD decoder.
module sssf_store import sssf_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEFAULT,
  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  store_wr_t     wr_i,
  input  logic [3:0]    eff_count_i,
  input  logic [AW-1:0] rd_idx_i,
  output logic [6:0]    rd_data_o
);

  logic [6:0] store_q [MAX_DIGITS];
  logic       wr_hit;
  logic [6:0] wr_image;

  // Slots at or beyond the scanned count are not written.
  assign wr_hit   = wr_i.en && ({2'b00, wr_i.position} < {1'b0, eff_count_i});
  assign wr_image = bcd_to_seg(wr_i.bcd);

  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_slot
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        store_q[i] <= SEGMENTS_BLANK;
      end else if (wr_hit && ({2'b00, wr_i.position} == 5'(i))) begin
        store_q[i] <= wr_image;
      end else if (wr_i.en && wr_i.clear) begin
        store_q[i] <= SEGMENTS_BLANK;
      end
    end
  end

  assign rd_data_o = store_q[rd_idx_i];

endmodule

FILE: hdl/sssf_scan.sv
// Scan sequencer: active digit, flash counter and the result register.
// Depends on sssf_pkg for cfg_t and cfg_evt_t.
module sssf_scan import sssf_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEFAULT,
  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  cfg_evt_t      evt_i,
  input  logic          tick_i,
  output logic          res_ready_o,
  output logic [AW-1:0] rd_idx_o,
  input  logic [6:0]    rd_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_digit_select_o,
  output logic [6:0]    out_segments_o
);

  localparam int unsigned RESET_COUNT =
      (DIGIT_COUNT_RESET > MAX_DIGITS) ? MAX_DIGITS : DIGIT_COUNT_RESET;

  logic [AW-1:0] active_q, active_d;
  logic [15:0]   flash_q, flash_d;
  logic          out_valid_q;
  logic [7:0]    sel_q, sel_d;
  logic [6:0]    seg_q, seg_d;
  logic [4:0]    act_inc;
  logic [15:0]   cnt_inc;
  logic [15:0]   cnt_wrap;
  logic [3:0]    last_digit;
  logic          flash_on;
  logic          in_range;
  logic          blank;

  assign res_ready_o = !out_valid_q || !out_stall_i;

  always_comb begin
    act_inc  = 5'(active_q) + 5'd1;
    active_d = (act_inc >= {1'b0, cfg_i.eff_count}) ? '0 : act_inc[AW-1:0];

    // The blink counter moves once per full scan, on the visit to digit zero.
    flash_on = cfg_i.flash_period != 16'd0;
    cnt_inc  = flash_q + 16'd1;
    cnt_wrap = (cnt_inc >= cfg_i.flash_period) ? 16'd0 : cnt_inc;
    flash_d  = (flash_on && (active_d == '0)) ? cnt_wrap : flash_q;

    in_range = (5'(active_d) >= {2'b00, cfg_i.flash_first})
            && (5'(active_d) <= {2'b00, cfg_i.flash_last});
    blank    = flash_on && in_range && (flash_d >= (cfg_i.flash_period >> 1));
    seg_d    = blank ? SEGMENTS_BLANK : rd_data_i;

    for (int b = 0; b < 8; b++) begin
      sel_d[b] = 5'(active_d) == 5'(b);
    end
  end

  assign rd_idx_o   = active_d;
  assign last_digit = cfg_i.eff_count - 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= AW'(RESET_COUNT - 1);
      flash_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (evt_i.restart) begin
        active_q <= AW'(last_digit);
      end else if (tick_i) begin
        active_q <= active_d;
      end
      if (evt_i.flash_clr) begin
        flash_q <= '0;
      end else if (tick_i) begin
        flash_q <= flash_d;
      end
      if (tick_i) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_o) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i) begin
      sel_q <= sel_d;
      seg_q <= seg_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_digit_select_o = sel_q;
  assign out_segments_o     = seg_q;

`ifndef SYNTHESIS
  a_active_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_i.restart || ({1'b0, active_q} < {1'b0, cfg_i.eff_count}))
    else $error("active digit beyond the scanned count");

  a_flash_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_i.flash_clr || (cfg_i.flash_period == 16'd0) || (flash_q < cfg_i.flash_period))
    else $error("flash counter at or above its period");

  a_tick_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_i |-> res_ready_o)
    else $error("tick would overwrite an undelivered result");

  a_result_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0(sel_q))
    else $error("digit select is not one-hot");
`endif

endmodule

FILE: hdl/seven_segment_scan_flash.sv
// Top level of the multiplexed seven-segment scanner with range blinking.
// Depends on sssf_pkg, sssf_cfg, sssf_store and sssf_scan.
//
// Usage: each word on the input channel is either a digit write (opcode 0)
// or a refresh tick (opcode 1). A write decodes a BCD value into a segment
// image and stores it at a digit position, optionally blanking the whole
// store first; it produces no output word. A tick moves the scan to the next
// digit and produces one output word: a one-hot digit select and the
// segments to drive, blanked while that digit is in the blink window.
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. The input word lands in an input register and is processed from
// there; a tick's result is then loaded into the output register and is
// shown from it until the receiver takes it. One word is taken every cycle;
// the single output register is the only limit, so a tick waits in the input
// register while a result is held by a stalled receiver, and the input stalls
// with it. The configuration channel (valid/ready, always ready) writes the
// digit count, flash range and flash period, and must be used only while the
// block is idle; the block itself does not enforce this. After reset the
// store is blank, the count is eight, blinking is off, and the first tick
// drives digit zero.
module seven_segment_scan_flash import sssf_pkg::*; #(
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_opcode_i,
  input  logic        in_clear_first_i,
  input  logic [2:0]  in_digit_position_i,
  input  logic [3:0]  in_bcd_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_digit_select_o,
  output logic [6:0]  out_segments_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  // Input register.
  logic       s1_valid_q;
  op_e        s1_op_q;
  logic       s1_clr_q;
  logic [2:0] s1_pos_q;
  logic [3:0] s1_bcd_q;

  logic          s1_fire;
  logic          s1_load;
  logic          tick;
  logic          res_ready;
  cfg_t          cfg;
  cfg_evt_t      evt;
  store_wr_t     store_wr;
  logic [AW-1:0] rd_idx;
  logic [6:0]    rd_data;

  // Writes retire at once; a tick needs a free output register.
  assign tick       = s1_valid_q && (s1_op_q == OP_TICK) && res_ready;
  assign s1_fire    = s1_valid_q && ((s1_op_q == OP_WRITE) || res_ready);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_op_q  <= op_e'(in_opcode_i);
      s1_clr_q <= in_clear_first_i;
      s1_pos_q <= in_digit_position_i;
      s1_bcd_q <= in_bcd_value_i;
    end
  end

  assign store_wr.en       = s1_valid_q && (s1_op_q == OP_WRITE);
  assign store_wr.clear    = s1_clr_q;
  assign store_wr.position = s1_pos_q;
  assign store_wr.bcd      = s1_bcd_q;

  sssf_cfg #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .evt_o       (evt)
  );

  sssf_store #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (store_wr),
    .eff_count_i (cfg.eff_count),
    .rd_idx_i    (rd_idx),
    .rd_data_o   (rd_data)
  );

  sssf_scan #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_scan (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .evt_i              (evt),
    .tick_i             (tick),
    .res_ready_o        (res_ready),
    .rd_idx_o           (rd_idx),
    .rd_data_i          (rd_data),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_digit_select_o (out_digit_select_o),
    .out_segments_o     (out_segments_o)
  );

`ifndef SYNTHESIS
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && (s1_op_q == OP_TICK)))
    else $error("input stalled without a waiting tick");

  a_stall_held_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> (s1_valid_q && $stable(s1_op_q)))
    else $error("waiting tick lost from the input register");
`endif

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the seven_segment_scan_flash scanner.
// Depends on sssf_pkg and the seven_segment_scan_flash RTL; it needs no
// other files.
module tb;
  import sssf_pkg::*;

  localparam int unsigned SLOTS         = MAX_DIGITS_DEFAULT;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned PRINT_CAP     = 100;
  localparam int unsigned PHASE_ITEMS   = 200;

  // Segment images of the BCD digits zero through nine. The nine has no
  // bottom segment.
  localparam logic [6:0] DIGIT_GLYPH [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
  };

  // One input word: a digit write or a refresh tick.
  typedef struct packed {
    op_e        opcode;
    logic       clear_first;
    logic [2:0] position;
    logic [3:0] bcd;
  } scan_cmd_t;

  // One output word: the digit now lit and its segments.
  typedef struct packed {
    logic [7:0] digit_select;
    logic [6:0] segments;
  } scan_word_t;

  logic        clk_i               = 1'b0;
  logic        rst_ni              = 1'b0;
  logic        in_valid_i          = 1'b0;
  logic        in_stall_o;
  logic        in_opcode_i         = 1'b0;
  logic        in_clear_first_i    = 1'b0;
  logic [2:0]  in_digit_position_i = '0;
  logic [3:0]  in_bcd_value_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i         = 1'b0;
  logic [7:0]  out_digit_select_o;
  logic [6:0]  out_segments_o;
  logic        cfg_valid_i         = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i         = '0;
  logic [15:0] cfg_data_i          = '0;

  seven_segment_scan_flash u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_opcode_i        (in_opcode_i),
    .in_clear_first_i   (in_clear_first_i),
    .in_digit_position_i(in_digit_position_i),
    .in_bcd_value_i     (in_bcd_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_digit_select_o (out_digit_select_o),
    .out_segments_o     (out_segments_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Words waiting to be offered, and the display words predicted so far.
  scan_cmd_t   cmd_backlog[$];
  scan_word_t  words_due[$];

  int unsigned cycles     = 0;
  int unsigned mismatches = 0;

  // Percentages of cycles in which the sender leaves its valid low and the
  // receiver raises its stall.
  int unsigned send_gap_pct   = 33;
  int unsigned recv_stall_pct = 64;

  // A long receiver hold-off is requested by bumping hold_requests; the
  // receiver process counts the stretch down on its own.
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  logic        in_word_taken = 1'b0;
  scan_cmd_t   next_cmd;
  scan_word_t  due_word;

  // Shadow of the scanner: digit store, scan position, blink counter and the
  // four registers as last written.
  logic [6:0]  glyph_store [SLOTS];
  logic [2:0]  scan_pos    = 3'(SLOTS - 1);
  logic [15:0] blink_ctr   = '0;
  logic [3:0]  reg_count   = 4'(DIGIT_COUNT_RESET);
  logic [2:0]  reg_first   = '0;
  logic [2:0]  reg_last    = '0;
  logic [15:0] reg_period  = '0;

  initial begin
    foreach (glyph_store[i]) glyph_store[i] = '0;
  end

  // Every index past the register list is a no-op write.
  localparam logic [3:0] CFG_INDEX_FIRST_UNUSED = 4'(CFG_FLASH_PERIOD) + 4'd1;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("ERROR cycle %0d: %s", cycles, what);
    end
  endtask

  // A count of zero scans one digit; counts above the slot number saturate.
  function automatic int unsigned scanned_digits();
    int unsigned n;
    n = reg_count;
    if (n == 0) n = 1;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  function automatic void apply_cfg_write(input logic [3:0] idx, input logic [15:0] data);
    case (idx)
      CFG_DIGIT_COUNT: begin
        reg_count = data[3:0];
        // The scan restarts so the next tick lights digit zero.
        scan_pos  = 3'(scanned_digits() - 1);
      end
      CFG_FLASH_FIRST: begin
        reg_first = data[2:0];
        blink_ctr = '0;
      end
      CFG_FLASH_LAST: begin
        reg_last  = data[2:0];
        blink_ctr = '0;
      end
      CFG_FLASH_PERIOD: begin
        reg_period = data;
        blink_ctr  = '0;
      end
      default: ;
    endcase
  endfunction

  // Advance the shadow by one accepted input word and queue the display word
  // that a tick produces.
  function automatic void predict_display(input scan_cmd_t cmd);
    int unsigned digits;
    scan_word_t  w;
    digits = scanned_digits();
    if (cmd.opcode == OP_WRITE) begin
      if (cmd.clear_first) begin
        foreach (glyph_store[i]) glyph_store[i] = '0;
      end
      // Positions outside the scanned digits are dropped, after any clear.
      if (cmd.position < digits) begin
        glyph_store[cmd.position] = (cmd.bcd <= 4'd9) ? DIGIT_GLYPH[cmd.bcd] : 7'h00;
      end
    end else begin
      scan_pos = 3'((int'(scan_pos) + 1) % digits);
      w.segments = glyph_store[scan_pos];
      if (reg_period != 0) begin
        if (scan_pos == 0) begin
          blink_ctr = blink_ctr + 16'd1;
          if (blink_ctr >= reg_period) blink_ctr = '0;
        end
        // The upper half of the period blanks the blink range; an inverted
        // range covers nothing.
        if (scan_pos >= reg_first && scan_pos <= reg_last &&
            blink_ctr >= (reg_period >> 1)) begin
          w.segments = 7'h00;
        end
      end
      w.digit_select = 8'(1 << scan_pos);
      words_due.push_back(w);
    end
  endfunction

  // Sender: a new word goes out at the falling edge once the previous one has
  // been taken. The choice to idle is random and never looks at the stall.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_word_taken)) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_cmd            = cmd_backlog.pop_front();
        in_valid_i          <= 1'b1;
        in_opcode_i         <= next_cmd.opcode;
        in_clear_first_i    <= next_cmd.clear_first;
        in_digit_position_i <= next_cmd.position;
        in_bcd_value_i      <= next_cmd.bcd;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one has been requested.
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Both channels are sampled at the rising edge. The output word is checked
  // before the input word of the same edge enters the shadow, since a tick's
  // word cannot leave in the cycle it is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (words_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word: select %02h segments %02h",
                                    out_digit_select_o, out_segments_o));
        end else begin
          due_word = words_due.pop_front();
          if (out_digit_select_o !== due_word.digit_select) begin
            report_mismatch($sformatf("digit select %02h, predicted %02h",
                                      out_digit_select_o, due_word.digit_select));
          end
          if (out_segments_o !== due_word.segments) begin
            report_mismatch($sformatf("segments %02h, predicted %02h (select %02h)",
                                      out_segments_o, due_word.segments,
                                      due_word.digit_select));
          end
        end
      end
      in_word_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        predict_display(scan_cmd_t'({op_e'(in_opcode_i), in_clear_first_i,
                                     in_digit_position_i, in_bcd_value_i}));
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("seven_segment_scan_flash: mismatch");
      $finish;
    end
  end

  function automatic void push_write(input logic clr, input logic [2:0] pos,
                                     input logic [3:0] bcd);
    cmd_backlog.push_back(scan_cmd_t'({OP_WRITE, clr, pos, bcd}));
  endfunction

  // The write fields ride along on a tick and must be ignored.
  function automatic void push_tick(input logic clr, input logic [2:0] pos,
                                    input logic [3:0] bcd);
    cmd_backlog.push_back(scan_cmd_t'({OP_TICK, clr, pos, bcd}));
  endfunction

  // Queue a batch of random words. Writes mostly land on scanned positions
  // so the store fills up; clears are kept rare so blanks do not dominate.
  function automatic void push_random_words(input int unsigned n);
    int unsigned digits;
    logic [2:0]  pos;
    digits = scanned_digits();
    repeat (n) begin
      if ($urandom_range(99) < 40) begin
        if ($urandom_range(99) < 80) pos = 3'($urandom_range(digits - 1, 0));
        else pos = 3'($urandom_range(7, 0));
        push_write($urandom_range(99) < 8, pos, 4'($urandom_range(15, 0)));
      end else begin
        push_tick(1'($urandom), 3'($urandom), 4'($urandom));
      end
    end
  endfunction

  // Blocks until every queued word is taken and every predicted word is out.
  task automatic wait_display_idle();
    while (cmd_backlog.size() != 0 || in_valid_i || words_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_cfg_write(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Registers change only with the block idle. A write word never produces
  // output, so after the last display word the task still lets any write in
  // flight finish before the registers change. Unused upper data bits are
  // randomized to show that they are ignored.
  task automatic load_display_cfg(input logic [3:0] count, input logic [2:0] first,
                                  input logic [2:0] last, input logic [15:0] period,
                                  input bit poke_unused);
    wait_display_idle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    write_reg(CFG_FLASH_FIRST, {13'($urandom), first});
    write_reg(CFG_FLASH_LAST, {13'($urandom), last});
    write_reg(CFG_FLASH_PERIOD, period);
    if (poke_unused) begin
      write_reg(4'($urandom_range(15, CFG_INDEX_FIRST_UNUSED)), 16'($urandom));
    end
    write_reg(CFG_DIGIT_COUNT, {12'($urandom), count});
  endtask

  function automatic logic [15:0] pick_period();
    case ($urandom_range(3, 0))
      0: return 16'd0;
      1: return 16'($urandom);
      default: return 16'($urandom_range(12, 1));
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset settings: every BCD value up to nine, the blanks
    // ten and fifteen, every position, a full scan of eight digits, a clear-first
    // write, and ticks carrying all-zero and all-one junk fields.
    for (int p = 0; p < 8; p++) push_write(1'b0, 3'(p), 4'(p));
    push_write(1'b0, 3'd0, 4'd8);
    push_write(1'b0, 3'd1, 4'd9);
    push_write(1'b0, 3'd2, 4'd10);
    push_write(1'b0, 3'd7, 4'd15);
    for (int t = 0; t < 8; t++) begin
      if (t[0]) push_tick(1'b1, 3'd7, 4'd15);
      else push_tick(1'b0, 3'd0, 4'd0);
    end
    push_write(1'b1, 3'd3, 4'd9);
    repeat (4) push_tick(1'b1, 3'd7, 4'd15);

    // Random part, one register setting per phase. The fixed settings cover
    // a period of one (range always blank), a count of zero with a period of
    // two, a count above the slot number with an inverted range, a single
    // digit with the longest period, and the widest blink range.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_display_cfg(4'd3, 3'd0, 3'd7, 16'd1, 1'b1);
        1: load_display_cfg(4'd0, 3'd0, 3'd0, 16'd2, 1'b0);
        2: load_display_cfg(4'd15, 3'd5, 3'd2, 16'd4, 1'b1);
        3: load_display_cfg(4'd8, 3'd2, 3'd5, 16'd6, 1'b0);
        4: load_display_cfg(4'd1, 3'd0, 3'd0, 16'hFFFF, 1'b1);
        7: load_display_cfg(4'd8, 3'd0, 3'd7, 16'd3, 1'b0);
        default: load_display_cfg(4'($urandom_range(15, 0)), 3'($urandom),
                                  3'($urandom), pick_period(), 1'b1);
      endcase

      // Idle mix: receiver sparse first, then sender sparse, then full rate.
      if (ph < 3) begin
        send_gap_pct   = 33;
        recv_stall_pct = 64;
      end else if (ph < 6) begin
        send_gap_pct   = 64;
        recv_stall_pct = 33;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end

      if (ph == 1) begin
        // Hold the receiver off while ticks keep coming, so the output
        // register fills and the input side has to stall.
        push_random_words(PHASE_ITEMS);
        hold_requests++;
      end else if (ph == 4) begin
        // The sender stops halfway until every display word has drained.
        push_random_words(PHASE_ITEMS / 2);
        wait_display_idle();
        push_random_words(PHASE_ITEMS / 2);
      end else begin
        push_random_words(PHASE_ITEMS);
      end
    end

    wait_display_idle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (words_due.size() != 0) begin
      report_mismatch($sformatf("%0d display words never arrived", words_due.size()));
    end
    if (mismatches == 0) begin
      $display("seven_segment_scan_flash: match");
    end else begin
      $display("seven_segment_scan_flash: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/sssf_pkg.sv
hdl/sssf_cfg.sv
hdl/sssf_store.sv
hdl/sssf_scan.sv
hdl/seven_segment_scan_flash.sv
sim/tb.sv
